### sv/ldlc_pkg.sv
// Package for the LED dimming level calculator.
// Holds the item types, mode/status/register codes and the divider step functions.
// No dependencies.
package ldlc_pkg;

  // Number of quotient bits, one per divider stage.
  localparam int DIV_STAGES = 16;

  localparam logic [15:0] SENSOR_LIMIT = 16'd4095;

  typedef enum logic [1:0] {
    MODE_MANUAL     = 2'd0,
    MODE_AUTOSENSOR = 2'd1,
    MODE_AUTOTIME   = 2'd2,
    MODE_INVALID    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SENSOR  = 3'd1,
    ST_THRESH  = 3'd2,
    ST_MODE    = 3'd3,
    ST_ENCODER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_MODE            = 3'd0,
    CFG_THRESHOLD_LOW   = 3'd1,
    CFG_THRESHOLD_HIGH  = 3'd2,
    CFG_AUTO_FULL_SCALE = 3'd3,
    CFG_PWM_MAX         = 3'd4,
    CFG_ENC_WRAP        = 3'd5
  } cfg_index_t;

  localparam mode_t       RST_MODE            = MODE_AUTOSENSOR;
  localparam logic [11:0] RST_THRESHOLD_LOW   = 12'd400;
  localparam logic [11:0] RST_THRESHOLD_HIGH  = 12'd1800;
  localparam logic [15:0] RST_AUTO_FULL_SCALE = 16'd1279;
  localparam logic [15:0] RST_PWM_MAX         = 16'd1279;
  localparam logic [15:0] RST_ENC_WRAP        = 16'd99;

  typedef struct packed {
    logic [15:0] light_sample;
    logic [15:0] encoder_count;
  } item_t;

  typedef struct packed {
    logic [15:0] fill;
    logic [2:0]  status;
  } result_t;

  // Classified request handed from the front to the divider.
  typedef struct packed {
    logic        use_div;
    logic        neg;
    logic [15:0] base;
    status_t     status;
    logic [31:0] product;
    logic [15:0] divisor;
  } div_entry_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic        use_div;
    logic        neg;
    logic [15:0] base;
    status_t     status;
    logic [15:0] rem;
    logic [15:0] nq;
    logic [15:0] divisor;
  } div_stage_t;

  function automatic div_stage_t div_load(div_entry_t e);
    div_stage_t s;
    s.use_div = e.use_div;
    s.neg     = e.neg;
    s.base    = e.base;
    s.status  = e.status;
    s.rem     = e.product[31:16];
    s.nq      = e.product[15:0];
    s.divisor = e.divisor;
    return s;
  endfunction

  // One quotient bit: shift in the next dividend bit, compare and subtract.
  function automatic div_stage_t div_step(div_stage_t s);
    logic [16:0] r2;
    logic [16:0] diff;
    logic        ge;
    div_stage_t  o;
    r2   = {s.rem, s.nq[15]};
    diff = r2 - {1'b0, s.divisor};
    ge   = (r2 >= {1'b0, s.divisor});
    o    = s;
    o.rem = ge ? diff[15:0] : r2[15:0];
    o.nq  = {s.nq[14:0], ge};
    return o;
  endfunction

endpackage

### sv/ldlc_fifo.sv
// Small register-based FIFO used between the front and the divider and at the output.
// No package dependencies.
module ldlc_fifo #(
  parameter int WIDTH      = 1,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = 2 ** DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign full    = (count == (DEPTH_LOG2 + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

### sv/ldlc_front.sv
// Front end: configuration registers, input acceptance, classification and multiply.
// Depends on ldlc_pkg.
module ldlc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                push,
  input  ldlc_pkg::item_t     item,
  output logic                full,
  input  logic                mid_full,
  output logic                mid_push,
  output ldlc_pkg::div_entry_t mid_entry
);

  import ldlc_pkg::*;

  mode_t       mode;
  logic [11:0] threshold_low;
  logic [11:0] threshold_high;
  logic [15:0] auto_full_scale;
  logic [15:0] pwm_max;
  logic [15:0] enc_wrap;

  logic        stage_vld;
  div_entry_t  stage;
  div_entry_t  stage_next;
  logic        accept;

  logic [15:0] mult_a;
  logic [15:0] mult_b;
  logic [11:0] offset;
  logic [11:0] span;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= RST_MODE;
      threshold_low   <= RST_THRESHOLD_LOW;
      threshold_high  <= RST_THRESHOLD_HIGH;
      auto_full_scale <= RST_AUTO_FULL_SCALE;
      pwm_max         <= RST_PWM_MAX;
      enc_wrap        <= RST_ENC_WRAP;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE:            mode            <= mode_t'(cfg_data[1:0]);
        CFG_THRESHOLD_LOW:   threshold_low   <= cfg_data[11:0];
        CFG_THRESHOLD_HIGH:  threshold_high  <= cfg_data[11:0];
        CFG_AUTO_FULL_SCALE: auto_full_scale <= cfg_data;
        CFG_PWM_MAX:         pwm_max         <= cfg_data;
        CFG_ENC_WRAP:        enc_wrap        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full     = stage_vld && mid_full;
  assign accept   = push && !full;
  assign mid_push = stage_vld && !mid_full;
  assign mid_entry = stage;

  assign offset = item.light_sample[11:0] - threshold_low;
  assign span   = threshold_high - threshold_low;

  always_comb begin
    mult_a = auto_full_scale;
    mult_b = {4'd0, offset};
    stage_next.use_div = 1'b0;
    stage_next.neg     = 1'b0;
    stage_next.base    = '0;
    stage_next.status  = ST_OK;
    stage_next.divisor = {4'd0, span};
    unique case (mode)
      MODE_MANUAL: begin
        mult_a = pwm_max;
        mult_b = item.encoder_count;
        stage_next.divisor = enc_wrap;
        if (enc_wrap == '0 || item.encoder_count > enc_wrap) begin
          stage_next.status = ST_ENCODER;
        end else begin
          stage_next.use_div = 1'b1;
          stage_next.neg     = 1'b1;
          stage_next.base    = pwm_max;
        end
      end
      MODE_AUTOSENSOR: begin
        priority if (item.light_sample > SENSOR_LIMIT) begin
          stage_next.status = ST_SENSOR;
        end else if (item.light_sample < {4'd0, threshold_low}) begin
          stage_next.base = '0;
        end else if (item.light_sample > {4'd0, threshold_high}) begin
          stage_next.base = auto_full_scale;
        end else if (threshold_low >= threshold_high || threshold_low == '0 ||
                     threshold_high == '0) begin
          stage_next.status = ST_THRESH;
        end else begin
          stage_next.use_div = 1'b1;
        end
      end
      MODE_AUTOTIME: begin
        stage_next.base = '0;
      end
      MODE_INVALID: begin
        stage_next.status = ST_MODE;
      end
    endcase
    // Items that need no division carry a zero dividend.
    stage_next.product = stage_next.use_div ? (mult_a * mult_b) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
    end else if (accept) begin
      stage_vld <= (mode != MODE_AUTOTIME);
    end else if (mid_push) begin
      stage_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stage <= stage_next;
  end

endmodule

### sv/ldlc_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, and fill assembly.
// Depends on ldlc_pkg.
module ldlc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mid_empty,
  input  ldlc_pkg::div_entry_t mid_entry,
  output logic                 mid_pop,
  input  logic                 out_full,
  output logic                 out_push,
  output ldlc_pkg::result_t    out_item
);

  import ldlc_pkg::*;

  div_stage_t            pipe [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic                  adv;
  div_stage_t            last;

  // The whole pipeline holds only when its last result cannot leave.
  assign adv     = !(vld[DIV_STAGES-1] && out_full);
  assign mid_pop = adv && !mid_empty;
  assign last    = pipe[DIV_STAGES-1];
  assign out_push = vld[DIV_STAGES-1] && !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-2:0], !mid_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= div_step(div_load(mid_entry));
      for (int k = 1; k < DIV_STAGES; k++) begin
        pipe[k] <= div_step(pipe[k-1]);
      end
    end
  end

  always_comb begin
    out_item.status = last.status;
    if (!last.use_div) begin
      out_item.fill = last.base;
    end else if (last.neg) begin
      out_item.fill = last.base - last.nq;
    end else begin
      out_item.fill = last.nq;
    end
  end

endmodule

### sv/led_dimming_level_calc_unit.sv
// LED dimming level calculator: top level joining front end, request queue, divider and
// result queue. Depends on ldlc_pkg, ldlc_front, ldlc_fifo and ldlc_back.
// A request passes the front stage register, request queue, divider and result queue.
// One request per cycle through the 16-stage divider while the result queue has room.
// Reset loads the default configuration and empties both queues and the divider.
module led_dimming_level_calc_unit #(
  parameter int MID_DEPTH_LOG2 = 2,
  parameter int OUT_DEPTH_LOG2 = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              push,
  output logic              full,
  input  ldlc_pkg::item_t   item,
  input  logic              pop,
  output logic              empty,
  output ldlc_pkg::result_t result
);

  import ldlc_pkg::*;

  // The front end classifies each request and forms the dividend with a single
  // 16x16 multiply. Autotime requests are taken and dropped there, so they never
  // reach the divider and produce no result.
  logic       mid_push;
  logic       mid_full;
  div_entry_t mid_wr;
  logic       mid_pop;
  logic       mid_empty;
  div_entry_t mid_rd;

  // Result path: the divider output lands in a small queue so the divider keeps
  // working while the consumer pauses.
  logic    out_push;
  logic    out_full;
  result_t out_wr;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  ldlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .full      (full),
    .mid_full  (mid_full),
    .mid_push  (mid_push),
    .mid_entry (mid_wr)
  );

  // Request queue between the front end and the divider.
  ldlc_fifo #(
    .WIDTH      ($bits(div_entry_t)),
    .DEPTH_LOG2 (MID_DEPTH_LOG2)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  // The divider computes floor(product / divisor); the quotient always fits in
  // 16 bits because the multiplier operand never exceeds the divisor.
  ldlc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_entry (mid_rd),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_wr)
  );

  // Result queue; its head drives the result port directly.
  ldlc_fifo #(
    .WIDTH      ($bits(result_t)),
    .DEPTH_LOG2 (OUT_DEPTH_LOG2)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_wr),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
